// File: hdl/agm_pkg.sv
package agm_pkg;

  localparam int CHANNELS       = 8;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int SAMPLE_W       = 16;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
  localparam int SUM_W          = SAMPLE_W + $clog2(CHANNELS);
  localparam int SCALED_W       = SUM_W + 1;
  localparam int NUM_W          = SAMPLE_W + GAIN_FRAC_BITS;
  localparam int CNT_W          = $clog2(CHANNELS + 1);
  localparam int DIV_CNT_W      = $clog2(NUM_W);
  localparam int RISE_SHIFT     = 5;
  localparam int IN_CH_MAX      = 8;
  localparam int IN_DATA_W      = IN_CH_MAX * SAMPLE_W + 8;
  localparam int MASK_LSB       = IN_CH_MAX * SAMPLE_W;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  localparam logic [SCALED_W-1:0] LIM_POS = SCALED_W'(32767);
  localparam logic [SCALED_W-1:0] LIM_NEG = SCALED_W'(32768);

  localparam logic [NUM_W-1:0] DIV_NUM_POS = {16'd32767, {GAIN_FRAC_BITS{1'b0}}};
  localparam logic [NUM_W-1:0] DIV_NUM_NEG = {16'd32768, {GAIN_FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic                    vld;
    logic signed [SUM_W-1:0] val;
  } lane_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]           count;
    logic signed [SAMPLE_W-1:0] last;
  } merge_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_st_t;

endpackage

// File: hdl/agm_lane.sv
module agm_lane (
  input  logic                                clk,
  input  logic                                load,
  input  logic signed [agm_pkg::SAMPLE_W-1:0] sample,
  input  logic                                vld,
  output agm_pkg::lane_t                      lane
);

  agm_pkg::lane_t lane_r;

  always_ff @(posedge clk) begin
    if (load) begin
      lane_r.vld <= vld;
      lane_r.val <= vld ? agm_pkg::SUM_W'(sample) : '0;
    end
  end

  assign lane = lane_r;

endmodule

// File: hdl/agm_merge.sv
module agm_merge (
  input  logic                                       clk,
  input  logic                                       load,
  input  agm_pkg::lane_t [agm_pkg::CHANNELS-1:0]     lanes,
  output agm_pkg::merge_t                            res
);

  agm_pkg::merge_t res_r;
  agm_pkg::merge_t res_nxt;

  always_comb begin
    res_nxt.sum   = '0;
    res_nxt.count = '0;
    res_nxt.last  = '0;
    for (int i = 0; i < agm_pkg::CHANNELS; i++) begin
      res_nxt.sum   = res_nxt.sum + lanes[i].val;
      res_nxt.count = res_nxt.count + agm_pkg::CNT_W'(lanes[i].vld);
      if (lanes[i].vld) begin
        res_nxt.last = lanes[i].val[agm_pkg::SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// File: hdl/agm_div.sv
module agm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [agm_pkg::NUM_W-1:0]     num,
  input  logic [agm_pkg::SCALED_W-1:0]  den,
  output agm_pkg::div_st_t              st,
  output logic [agm_pkg::NUM_W-1:0]     quo
);

  logic                           busy_r;
  logic                           done_r;
  logic [agm_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [agm_pkg::SCALED_W-1:0]   den_r;
  logic [agm_pkg::SCALED_W-1:0]   rem_r;
  logic [agm_pkg::NUM_W-1:0]      quo_r;
  logic [agm_pkg::SCALED_W:0]     shifted;
  logic [agm_pkg::SCALED_W:0]     diff;
  logic                           ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_r, quo_r[agm_pkg::NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = shifted >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= agm_pkg::DIV_CNT_W'(agm_pkg::NUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[agm_pkg::SCALED_W-1:0] : shifted[agm_pkg::SCALED_W-1:0];
      quo_r <= {quo_r[agm_pkg::NUM_W-2:0], ge};
    end
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign quo     = quo_r;

endmodule

// File: hdl/adaptive_gain_audio_mixer_unit.sv
// Adaptive-gain mixer for eight 16-bit channels. A request on in_ carries the samples, the
// channel mask and a frame start flag (tuser); frame start sets the gain to unity. A mask
// with no channel gives no result, one channel passes its sample through, two or more are
// summed by parallel lanes and a merge stage, scaled by the Q1.16 gain and saturated, with
// clipped on out_tuser. One request at a time: after acceptance it passes the sum, multiply
// and evaluate states; a single channel then goes straight to the output state, a mix that
// fits first passes the gain rise state, and a clip first waits for the 32-step bit-serial
// gain divider and then the rise state. A request with no valid channel frees the block
// from the evaluate state. A new request is taken while a result still waits on out_.
module adaptive_gain_audio_mixer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // sample_ch0 .. sample_ch7 (16 bits each), channel_valid (8 bits)
  input  logic [agm_pkg::IN_DATA_W-1:0]   in_tdata,
  // frame_start
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // mixed_sample
  output logic [15:0]                     out_tdata,
  // clipped
  output logic                            out_tuser
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MUL,
    S_EVAL,
    S_DIV,
    S_RISE,
    S_OUT
  } state_t;

  state_t                                state_r;
  logic [agm_pkg::GAIN_W-1:0]            gain_r;
  logic [agm_pkg::SCALED_W-1:0]          scaled_r;
  logic                                  neg_r;
  logic signed [agm_pkg::SAMPLE_W-1:0]   res_r;
  logic                                  clip_r;
  logic                                  out_valid_r;
  logic [15:0]                           out_data_r;
  logic                                  out_clip_r;
  logic                                  div_start;
  logic [agm_pkg::NUM_W-1:0]             div_num;

  logic                                  accept;
  agm_pkg::lane_t [agm_pkg::CHANNELS-1:0] lanes;
  agm_pkg::merge_t                       merged;
  agm_pkg::div_st_t                      div_st;
  logic [agm_pkg::NUM_W-1:0]             div_quo;
  logic [agm_pkg::SUM_W-1:0]             mag;
  logic [agm_pkg::SUM_W+agm_pkg::GAIN_W-1:0] full_prod;
  logic                                  clip_pos;
  logic                                  clip_neg;
  logic [agm_pkg::SCALED_W-1:0]          neg_scaled;
  logic [agm_pkg::GAIN_W-1:0]            gain_gap;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  for (genvar i = 0; i < agm_pkg::CHANNELS; i++) begin : g_lane
    agm_lane u_lane (
      .clk    (clk),
      .load   (accept),
      .sample (in_tdata[i*agm_pkg::SAMPLE_W +: agm_pkg::SAMPLE_W]),
      .vld    (in_tdata[agm_pkg::MASK_LSB + i]),
      .lane   (lanes[i])
    );
  end

  agm_merge u_merge (
    .clk   (clk),
    .load  (state_r == S_SUM),
    .lanes (lanes),
    .res   (merged)
  );

  agm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (scaled_r),
    .st    (div_st),
    .quo   (div_quo)
  );

  always_comb begin
    mag        = merged.sum[agm_pkg::SUM_W-1] ? agm_pkg::SUM_W'(-merged.sum)
                                              : agm_pkg::SUM_W'(merged.sum);
    full_prod  = agm_pkg::SUM_W'(mag) * gain_r;
    clip_pos   = !neg_r && (scaled_r > agm_pkg::LIM_POS);
    clip_neg   = neg_r && (scaled_r > agm_pkg::LIM_NEG);
    neg_scaled = -scaled_r;
    gain_gap   = agm_pkg::GAIN_UNITY - gain_r;
    div_start  = (state_r == S_EVAL) && (merged.count > agm_pkg::CNT_W'(1))
                 && (clip_pos || clip_neg);
    div_num    = clip_neg ? agm_pkg::DIV_NUM_NEG : agm_pkg::DIV_NUM_POS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= agm_pkg::GAIN_UNITY;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_tuser) begin
              gain_r <= agm_pkg::GAIN_UNITY;
            end
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          scaled_r <= full_prod[agm_pkg::GAIN_FRAC_BITS +: agm_pkg::SCALED_W];
          neg_r    <= merged.sum[agm_pkg::SUM_W-1];
          state_r  <= S_EVAL;
        end
        S_EVAL: begin
          if (merged.count == '0) begin
            state_r <= S_IDLE;
          end else if (merged.count == agm_pkg::CNT_W'(1)) begin
            res_r   <= merged.last;
            clip_r  <= 1'b0;
            state_r <= S_OUT;
          end else if (clip_pos) begin
            res_r   <= agm_pkg::SAMPLE_MAX;
            clip_r  <= 1'b1;
            state_r <= S_DIV;
          end else if (clip_neg) begin
            res_r   <= agm_pkg::SAMPLE_MIN;
            clip_r  <= 1'b1;
            state_r <= S_DIV;
          end else begin
            res_r   <= neg_r ? neg_scaled[agm_pkg::SAMPLE_W-1:0]
                             : scaled_r[agm_pkg::SAMPLE_W-1:0];
            clip_r  <= 1'b0;
            state_r <= S_RISE;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            gain_r  <= div_quo[agm_pkg::GAIN_W-1:0];
            state_r <= S_RISE;
          end
        end
        S_RISE: begin
          if (gain_r < agm_pkg::GAIN_UNITY) begin
            gain_r <= gain_r + (gain_gap >> agm_pkg::RISE_SHIFT);
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            out_clip_r  <= clip_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

`ifndef SYNTHESIS
  a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= agm_pkg::GAIN_UNITY)
    else $error("gain above unity");

  a_frame_unity: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tuser |=> gain_r == agm_pkg::GAIN_UNITY)
    else $error("frame start did not restore unity gain");

  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata == 16'h7fff || out_tdata == 16'h8000))
    else $error("clipped result not saturated");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == S_DIV)
    else $error("divider finished outside gain update");
`endif

endmodule
